@@ rtl/hdlcr_pkg.sv @@
// ----------------------------------------------------------------------------
// hdlcr_pkg
// Shared types, constants and the CRC-16 byte update for the HDLC receiver.
// ----------------------------------------------------------------------------
package hdlcr_pkg;

  localparam int unsigned LenW   = 9;
  localparam int unsigned RunW   = 3;
  localparam int unsigned FcsW   = 16;

  localparam logic [FcsW-1:0] FcsInit = 16'hFFFF;
  localparam logic [FcsW-1:0] FcsPoly = 16'h8408;   // reflected CCITT
  localparam logic [RunW-1:0] RunFlag = 3'd6;       // six ones then zero
  localparam logic [RunW-1:0] RunStuff = 3'd5;      // five ones then zero
  localparam logic [LenW-1:0] MinBytesReset = 9'd18;
  localparam logic [LenW-1:0] FcsBytes = 9'd2;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_GOOD  = 3'd1,
    KIND_SHORT = 3'd2,
    KIND_CRC   = 3'd3,
    KIND_LONG  = 3'd4,
    KIND_ABORT = 3'd5
  } kind_e;

  // Classification of one line bit after the ones-run check.
  typedef struct packed {
    logic is_abort;  // seventh one in a row
    logic is_flag;   // zero after six ones
    logic is_stuff;  // zero after five ones, dropped
    logic is_data;   // ordinary frame bit
  } bit_evt_t;

  // LSB-first CRC-16 update over one byte.
  function automatic logic [FcsW-1:0] crc_byte(input logic [FcsW-1:0] crc_in,
                                               input logic [7:0] b);
    logic [FcsW-1:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ FcsPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/hdlcr_destuff.sv @@
// ----------------------------------------------------------------------------
// hdlcr_destuff
// Ones-run counter: flags, aborts and stuffed bits on the received stream.
// ----------------------------------------------------------------------------
module hdlcr_destuff
  import hdlcr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     bit_fire_i,  // a bit is taken this cycle
  input  logic     bit_i,
  input  logic     clr_run_i,   // frame dropped for length, restart the run
  output bit_evt_t evt_o
);

  logic [RunW-1:0] ones_q, ones_d;

  always_comb begin
    evt_o.is_abort = bit_i && (ones_q == RunFlag);
    evt_o.is_flag  = !bit_i && (ones_q == RunFlag);
    evt_o.is_stuff = !bit_i && (ones_q == RunStuff);
    evt_o.is_data  = !(evt_o.is_abort || evt_o.is_flag || evt_o.is_stuff);
  end

  always_comb begin
    ones_d = ones_q;
    if (bit_fire_i) begin
      if (clr_run_i || !bit_i || evt_o.is_abort) begin
        ones_d = '0;
      end else begin
        ones_d = ones_q + RunW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ones_q <= '0;
    end else begin
      ones_q <= ones_d;
    end
  end

endmodule

@@ rtl/hdlc_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// hdlc_frame_receiver_core
// HDLC deframer: flag/abort detection, bit destuffing, byte assembly with a
// two-byte FCS holdback, CRC-16 check and one status item per frame.
// ----------------------------------------------------------------------------
// Output: a result item is registered and appears in the output register in the
//   cycle after the input bit that causes it is accepted.
// Throughput: one bit per cycle; the output register frees as it is taken,
//   so rx_ready_o only drops while a result waits and res_ready_i is low.
// Reset: asynchronous, active low; waits for a flag, min_frame_bytes = 18.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver_core
  import hdlcr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 288  // 18 .. 511
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  // received bits
  input  logic            rx_valid_i,
  output logic            rx_ready_o,
  input  logic            rx_bit_i,
  // result items
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [LenW-1:0] payload_length_o
);

  localparam logic [LenW-1:0] MaxBytes = LenW'(MAX_FRAME_BYTES);

  // Frame state
  logic            in_frame_q, in_frame_d;
  logic [7:0]      shift_q, shift_d;
  logic [2:0]      bit_pos_q, bit_pos_d;
  logic [LenW-1:0] total_q, total_d;
  logic [7:0]      older_q, older_d;      // oldest held byte, next to release
  logic [7:0]      newer_q, newer_d;
  logic [FcsW-1:0] fcs_q, fcs_d;
  logic [LenW-1:0] min_bytes_q;

  // Output register
  logic            res_valid_q, res_valid_d;
  kind_e           kind_q, kind_d;
  logic [7:0]      data_q, data_d;
  logic [LenW-1:0] len_q, len_d;
  logic            emit;

  logic            rx_fire;
  logic            clr_run;
  bit_evt_t        evt;
  logic [7:0]      shifted;
  logic [LenW-1:0] released;
  logic            fcs_match;
  logic            frame_open;

  // Output slot frees when empty or being taken in this cycle.
  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  hdlcr_destuff u_destuff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bit_fire_i (rx_fire),
    .bit_i      (rx_bit_i),
    .clr_run_i  (clr_run),
    .evt_o      (evt)
  );

  assign shifted    = {rx_bit_i, shift_q[7:1]};
  assign released   = (total_q >= FcsBytes) ? (total_q - FcsBytes) : '0;
  assign fcs_match  = (~fcs_q) == {newer_q, older_q};
  assign frame_open = in_frame_q && (total_q != '0);

  always_comb begin
    in_frame_d = in_frame_q;
    shift_d    = shift_q;
    bit_pos_d  = bit_pos_q;
    total_d    = total_q;
    older_d    = older_q;
    newer_d    = newer_q;
    fcs_d      = fcs_q;
    clr_run    = 1'b0;
    emit       = 1'b0;
    kind_d     = KIND_DATA;
    data_d     = '0;
    len_d      = '0;

    if (rx_fire) begin
      priority if (evt.is_abort || evt.is_flag) begin
        // Either way the frame restarts; a flag opens a new one.
        if (frame_open) begin
          emit  = 1'b1;
          len_d = released;
          priority if (evt.is_abort) begin
            kind_d = KIND_ABORT;
          end else if (total_q < FcsBytes || total_q < min_bytes_q) begin
            kind_d = KIND_SHORT;
          end else if (fcs_match) begin
            kind_d = KIND_GOOD;
          end else begin
            kind_d = KIND_CRC;
          end
        end
        in_frame_d = evt.is_flag;
        shift_d    = '0;
        bit_pos_d  = '0;
        total_d    = '0;
        older_d    = '0;
        newer_d    = '0;
        fcs_d      = FcsInit;
      end else if (evt.is_data && in_frame_q) begin
        shift_d = shifted;
        if (bit_pos_q != 3'd7) begin
          bit_pos_d = bit_pos_q + 3'd1;
        end else begin
          bit_pos_d = '0;
          if (total_q >= MaxBytes) begin
            // Over length: drop the frame and hunt for the next flag.
            emit       = 1'b1;
            kind_d     = KIND_LONG;
            len_d      = released;
            clr_run    = 1'b1;
            in_frame_d = 1'b0;
            shift_d    = '0;
            total_d    = '0;
            older_d    = '0;
            newer_d    = '0;
            fcs_d      = FcsInit;
          end else begin
            // Byte enters the holdback; the one pushed out is released.
            if (total_q >= FcsBytes) begin
              emit   = 1'b1;
              data_d = older_q;
              fcs_d  = crc_byte(fcs_q, older_q);
            end
            older_d = newer_q;
            newer_d = shifted;
            total_d = total_q + LenW'(1);
          end
        end
      end else begin
        // stuffed bit, or line noise outside a frame
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (rx_fire) begin
      res_valid_d = emit;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      shift_q     <= '0;
      bit_pos_q   <= '0;
      total_q     <= '0;
      older_q     <= '0;
      newer_q     <= '0;
      fcs_q       <= FcsInit;
      min_bytes_q <= MinBytesReset;
      res_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      shift_q     <= shift_d;
      bit_pos_q   <= bit_pos_d;
      total_q     <= total_d;
      older_q     <= older_d;
      newer_q     <= newer_d;
      fcs_q       <= fcs_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        min_bytes_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (rx_fire && emit) begin
      kind_q <= kind_d;
      data_q <= data_d;
      len_q  <= len_d;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign kind_o           = kind_q;
  assign data_byte_o      = data_q;
  assign payload_length_o = len_q;

`ifndef NO_ASSERTIONS
  // Outside a frame nothing is being assembled.
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (total_q == '0) && (bit_pos_q == '0))
    else $error("frame state left over outside a frame");

  // Byte count never passes the frame limit.
  a_total_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MaxBytes)
    else $error("byte count beyond frame limit");

  // Data items carry no length, status items carry no byte.
  a_data_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == KIND_DATA) |-> payload_length_o == '0)
    else $error("data item with nonzero length");

  a_status_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o != KIND_DATA) |-> data_byte_o == '0)
    else $error("status item with nonzero byte");

  // An accepted bit after a held result means the result was taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_ready_i |-> !rx_fire)
    else $error("result overwritten while stalled");
`endif

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// HDLC frame receiver testbench
// Sends a bit stream of flags, stuffed frames with good and broken FCS,
// ragged closes, aborts and line noise into the receiver.
// A scoreboard predicts every data byte and frame status from the line bits
// and checks each result item in order. Both handshakes stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hdlcr_pkg::*;

  localparam int unsigned MaxFrameBytes = 288;

  // one expected result item
  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    logic [LenW-1:0] len;
  } rx_result_t;

  // frame shapes the random stimulus draws from
  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_FCS,
    SHAPE_RAGGED,
    SHAPE_ABORT,
    SHAPE_NOISE
  } frame_shape_e;

  // Scoreboard: shadows the deframer state and queues the results each
  // accepted line bit should produce.
  class frame_scoreboard;
    logic [LenW-1:0] min_bytes;
    bit              in_frame;
    int unsigned     ones_run;
    logic [7:0]      byte_shift;
    int unsigned     bit_pos;
    int unsigned     byte_total;
    logic [7:0]      held_older;
    logic [7:0]      held_newer;
    logic [FcsW-1:0] fcs;
    rx_result_t      results_due[$];
    int unsigned     errors;

    function new();
      min_bytes = MinBytesReset;
      errors    = 0;
      restart(1'b0);
    endfunction

    static function logic [FcsW-1:0] fold_fcs(logic [FcsW-1:0] crc, logic [7:0] octet);
      logic [FcsW-1:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        c = (c >> 1) ^ ((c[0] ^ octet[i]) ? FcsPoly : '0);
      end
      return c;
    endfunction

    function void restart(bit open);
      in_frame   = open;
      ones_run   = 0;
      byte_shift = '0;
      bit_pos    = 0;
      byte_total = 0;
      held_older = '0;
      held_newer = '0;
      fcs        = FcsInit;
    endfunction

    // bytes already released, FCS excluded
    function logic [LenW-1:0] released();
      return (byte_total >= 2) ? LenW'(byte_total - 2) : '0;
    endfunction

    function void push(kind_e kind, logic [7:0] data, logic [LenW-1:0] len);
      rx_result_t r;
      r.kind = kind;
      r.data = data;
      r.len  = len;
      results_due.push_back(r);
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    // Called once per accepted line bit.
    function void take_line_bit(bit b);
      kind_e k;
      if (b) begin
        ones_run++;
        if (ones_run > 6) begin
          // abort only reported for a frame that got a whole byte
          if (in_frame && byte_total != 0) push(KIND_ABORT, '0, released());
          restart(1'b0);
          return;
        end
      end else begin
        if (ones_run == RunFlag) begin
          if (in_frame && byte_total != 0) begin
            if (byte_total < 2 || byte_total < min_bytes) begin
              k = KIND_SHORT;
            end else if (~fcs == {held_newer, held_older}) begin
              k = KIND_GOOD;
            end else begin
              k = KIND_CRC;
            end
            push(k, '0, released());
          end
          restart(1'b1);
          return;
        end
        if (ones_run == RunStuff) begin
          ones_run = 0;
          return;
        end
        ones_run = 0;
      end

      if (!in_frame) return;
      byte_shift = {b, byte_shift[7:1]};
      if (bit_pos < 7) begin
        bit_pos++;
        return;
      end
      bit_pos = 0;

      if (byte_total >= MaxFrameBytes) begin
        push(KIND_LONG, '0, released());
        restart(1'b0);
        return;
      end
      // two-byte holdback: the byte pushed out is released and checksummed
      if (byte_total >= 2) begin
        push(KIND_DATA, held_older, '0);
        fcs = fold_fcs(fcs, held_older);
      end
      held_older = held_newer;
      held_newer = byte_shift;
      byte_total++;
    endfunction

    function void check_result(logic [2:0] kind, logic [7:0] data, logic [LenW-1:0] len);
      rx_result_t want;
      if (results_due.size() == 0) begin
        $error("unexpected result item: kind %0d data %0h len %0d", kind, data, len);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (kind !== 3'(want.kind)) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (data !== want.data) begin
        $error("data_byte: expected %0h, actual %0h", want.data, data);
        errors++;
      end
      if (len !== want.len) begin
        $error("payload_length: expected %0d, actual %0d", want.len, len);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [LenW-1:0] cfg_wdata_i = '0;
  logic            rx_valid_i  = 1'b0;
  logic            rx_ready_o;
  logic            rx_bit_i    = 1'b0;
  logic            res_valid_o;
  logic            res_ready_i = 1'b0;
  logic [2:0]      kind_o;
  logic [7:0]      data_byte_o;
  logic [LenW-1:0] payload_length_o;

  frame_scoreboard sb = new();

  bit          idling_on    = 1'b1;  // random gaps on both sides
  bit          line_flagged = 1'b0;  // last thing sent was a closing flag
  int unsigned tx_ones      = 0;     // transmitter ones run, for stuffing
  int unsigned bits_sent    = 0;

  hdlc_frame_receiver_core #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .rx_valid_i,
    .rx_ready_o,
    .rx_bit_i,
    .res_valid_o,
    .res_ready_i,
    .kind_o,
    .data_byte_o,
    .payload_length_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: check accepted items, then pick ready for the next cycle.
  // Stalls come in random bursts.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_valid_o && res_ready_i) begin
        sb.check_result(kind_o, data_byte_o, payload_length_o);
      end
      if (stall_left != 0) begin
        stall_left--;
        res_ready_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        res_ready_i <= 1'b0;
      end else begin
        res_ready_i <= 1'b1;
      end
    end
  end

  // One line bit through the handshake. Valid stays up across back-to-back
  // items; an idle burst may drop it first.
  task automatic send_bit(bit b);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_bit_i   <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    sb.take_line_bit(b);
    bits_sent++;
  endtask

  task automatic send_flag();
    send_bit(1'b0);
    repeat (6) send_bit(1'b1);
    send_bit(1'b0);
    tx_ones = 0;
  endtask

  // frame bit with zero insertion after five ones
  task automatic send_stuffed(bit b);
    send_bit(b);
    tx_ones = b ? tx_ones + 1 : 0;
    if (tx_ones == 5) begin
      send_bit(1'b0);
      tx_ones = 0;
    end
  endtask

  task automatic send_octet(logic [7:0] octet);
    for (int i = 0; i < 8; i++) send_stuffed(octet[i]);
  endtask

  // bias toward patterns that trigger stuffing
  function automatic logic [7:0] pick_octet();
    case ($urandom_range(0, 7))
      0:       return 8'hFF;
      1:       return 8'h7E;
      2:       return 8'h3F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(frame_shape_e shape, int unsigned n);
    logic [7:0]      body[$];
    logic [FcsW-1:0] crc;
    logic [7:0]      octet;
    int unsigned     cut;
    crc = FcsInit;
    for (int unsigned i = 0; i < n; i++) begin
      octet = pick_octet();
      body.push_back(octet);
      crc = frame_scoreboard::fold_fcs(crc, octet);
    end
    crc = ~crc;
    if (shape == SHAPE_BAD_FCS && $urandom_range(0, 2) == 0) begin
      // no FCS at all: the last payload bytes end up held back
    end else begin
      if (shape == SHAPE_BAD_FCS) crc ^= FcsW'(1) << $urandom_range(0, FcsW - 1);
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
    end

    // back-to-back frames may share one flag
    if (!line_flagged || $urandom_range(0, 1) == 0) send_flag();

    if (shape == SHAPE_ABORT) begin
      cut = $urandom_range(0, body.size());
      for (int unsigned i = 0; i < cut; i++) send_octet(body[i]);
      repeat ($urandom_range(0, 7)) send_stuffed($urandom_range(0, 1));
      repeat ($urandom_range(7, 9)) send_bit(1'b1);
      line_flagged = 1'b0;
      return;
    end

    foreach (body[i]) send_octet(body[i]);
    // leftover bits before the flag are dropped by the receiver
    if (shape == SHAPE_RAGGED) repeat ($urandom_range(1, 7)) send_stuffed($urandom_range(0, 1));
    send_flag();
    line_flagged = 1'b1;
  endtask

  task automatic random_frame();
    int unsigned  pick;
    int unsigned  n;
    frame_shape_e shape;
    pick = $urandom_range(0, 99);
    if (pick < 55) shape = SHAPE_GOOD;
    else if (pick < 70) shape = SHAPE_BAD_FCS;
    else if (pick < 80) shape = SHAPE_RAGGED;
    else if (pick < 92) shape = SHAPE_ABORT;
    else shape = SHAPE_NOISE;

    if (shape == SHAPE_NOISE) begin
      // ones-heavy junk: stray flags, stuffing and aborts at random
      repeat ($urandom_range(8, 40)) send_bit($urandom_range(0, 2) != 0);
      line_flagged = 1'b0;
      return;
    end
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 30);
    send_frame(shape, n);
  endtask

  task automatic run_frames(int unsigned nbits);
    int unsigned goal;
    goal = bits_sent + nbits;
    while (bits_sent < goal) random_frame();
  endtask

  // Hold the sender until all results are in, plus slack for a bit still
  // in flight that makes no result.
  task automatic drain();
    rx_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_min_bytes(logic [LenW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.min_bytes = value;
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty frame between two flags, a one-byte frame whose
    // 0xFF needs a stuffed zero (always too short), then an abort on an
    // open frame with no bytes, which reports nothing.
    send_flag();
    send_flag();
    send_octet(8'hFF);
    send_flag();
    repeat (7) send_bit(1'b1);
    line_flagged = 1'b0;

    // default minimum of 18 bytes
    run_frames(180);

    write_min_bytes(LenW'(2));
    run_frames(150);

    // above the frame limit: nothing can pass as good
    write_min_bytes(LenW'(511));
    run_frames(120);

    // minimum at the frame limit
    write_min_bytes(LenW'(MaxFrameBytes));
    run_frames(60);

    write_min_bytes(LenW'($urandom_range(2, MaxFrameBytes)));
    run_frames(150);

    write_min_bytes(LenW'(0));
    run_frames(90);

    // last stretch back at the reset value with no idling on either side
    write_min_bytes(MinBytesReset);
    idling_on = 1'b0;
    run_frames(200);

    rx_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
